>>> hdl/dmp_pkg.sv
// package for the dns message parser: phase codes, token kinds, record types
// no dependencies
package dmp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE, PH_HDR, PH_NAME, PH_QTYPE, PH_QCLASS, PH_RTYPE, PH_RCLASS,
    PH_RTTL, PH_RDLEN, PH_RD_A, PH_RD_PREF, PH_RD_SKIP, PH_DONE
  } phase_e;

  localparam logic [3:0] TK_ID        = 4'd0;
  localparam logic [3:0] TK_FLAGS     = 4'd1;
  localparam logic [3:0] TK_QDCOUNT   = 4'd2;
  localparam logic [3:0] TK_ANCOUNT   = 4'd3;
  localparam logic [3:0] TK_NSCOUNT   = 4'd4;
  localparam logic [3:0] TK_ARCOUNT   = 4'd5;
  localparam logic [3:0] TK_NAME_CHAR = 4'd6;
  localparam logic [3:0] TK_NAME_END  = 4'd7;
  localparam logic [3:0] TK_TYPE      = 4'd8;
  localparam logic [3:0] TK_CLASS     = 4'd9;
  localparam logic [3:0] TK_TTL       = 4'd10;
  localparam logic [3:0] TK_RDLEN     = 4'd11;
  localparam logic [3:0] TK_ADDR      = 4'd12;
  localparam logic [3:0] TK_PREF      = 4'd13;
  localparam logic [3:0] TK_UNKNOWN   = 4'd14;
  localparam logic [3:0] TK_DONE      = 4'd15;

  localparam logic [15:0] TYPE_A     = 16'd1;
  localparam logic [15:0] TYPE_NS    = 16'd2;
  localparam logic [15:0] TYPE_CNAME = 16'd5;
  localparam logic [15:0] TYPE_PTR   = 16'd12;
  localparam logic [15:0] TYPE_MX    = 16'd15;

  localparam logic [2:0] SEC_HDR = 3'd0;
  localparam logic [2:0] SEC_QD  = 3'd1;
  localparam logic [2:0] SEC_AN  = 3'd2;
  localparam logic [2:0] SEC_NS  = 3'd3;
  localparam logic [2:0] SEC_AR  = 3'd4;

  localparam logic [7:0] DOT_CHAR = 8'd46;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  section;
    logic        role;
    logic [31:0] value;
    logic        is_flags;
  } token_t;

endpackage

>>> hdl/dmp_core.sv
// per-byte parser state and token decode, one byte per cycle while step_i is high
// depends on dmp_pkg
module dmp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  logic                first_byte_i,
  output logic                tok_valid_o,
  output dmp_pkg::token_t     tok_o
);

  dmp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  idx_q, idx_d;
  logic [2:0]  sec_q, sec_d;
  logic [15:0] left_q, left_d, an_q, an_d, ns_q, ns_d, ar_q, ar_d;
  logic [7:0]  lbl_q, lbl_d;
  logic        first_q, first_d, rd_q, rd_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] rtype_q, rtype_d, rdl_q, rdl_d;

  // working copies after an optional restart
  dmp_pkg::phase_e ph;
  logic [3:0]  idx;
  logic [2:0]  sec;
  logic [15:0] left, an, ns, ar;
  logic [7:0]  lbl;
  logic        fst, rd;
  logic [31:0] acc, shifted;
  logic [15:0] rtype, rdl;
  logic [3:0]  idx_inc;
  logic [15:0] hv;
  logic        known;

  // section walk after an item ends: next nonempty section, or done
  function automatic void seek(input logic [2:0] s_in, input logic [15:0] l_in,
                               input logic [15:0] a, input logic [15:0] n,
                               input logic [15:0] r, output logic [2:0] s_out,
                               output logic [15:0] l_out, output logic done);
    s_out = s_in; l_out = l_in; done = 1'b0;
    if (l_in == '0) begin
      if (s_in == dmp_pkg::SEC_QD && a != '0) begin
        s_out = dmp_pkg::SEC_AN; l_out = a;
      end else if ((s_in == dmp_pkg::SEC_QD || s_in == dmp_pkg::SEC_AN) && n != '0) begin
        s_out = dmp_pkg::SEC_NS; l_out = n;
      end else if (s_in != dmp_pkg::SEC_AR && s_in <= dmp_pkg::SEC_NS && s_in != '0
                   && r != '0) begin
        s_out = dmp_pkg::SEC_AR; l_out = r;
      end else begin
        s_out = dmp_pkg::SEC_AR; l_out = '0; done = 1'b1;
      end
    end
  endfunction

  logic [2:0]  sk_sec;
  logic [15:0] sk_left;
  logic        sk_done;

  always_comb begin
    ph = phase_q; idx = idx_q; sec = sec_q; left = left_q; an = an_q; ns = ns_q;
    ar = ar_q; lbl = lbl_q; fst = first_q; rd = rd_q; acc = acc_q;
    rtype = rtype_q; rdl = rdl_q;
    if (first_byte_i) begin
      ph = dmp_pkg::PH_HDR; idx = '0; sec = '0; left = '0; an = '0; ns = '0;
      ar = '0; lbl = '0; fst = 1'b1; rd = 1'b0; acc = '0; rtype = '0; rdl = '0;
    end
    shifted = {acc[23:0], data_byte_i};
    idx_inc = idx + 4'd1;
    hv      = {acc[7:0], data_byte_i};
    known   = shifted[15:0] == dmp_pkg::TYPE_A || shifted[15:0] == dmp_pkg::TYPE_NS ||
              shifted[15:0] == dmp_pkg::TYPE_CNAME || shifted[15:0] == dmp_pkg::TYPE_PTR ||
              shifted[15:0] == dmp_pkg::TYPE_MX;
  end

  // end of an item: count down and seek; also used from header end with count as is
  always_comb begin
    seek(sec == dmp_pkg::SEC_HDR ? dmp_pkg::SEC_QD : sec,
         (ph == dmp_pkg::PH_HDR) ? left : left - 16'd1, an, ns,
         (ph == dmp_pkg::PH_HDR) ? hv : ar, sk_sec, sk_left, sk_done);
  end

  always_comb begin
    phase_d = ph; idx_d = idx; sec_d = sec; left_d = left; an_d = an; ns_d = ns;
    ar_d = ar; lbl_d = lbl; first_d = fst; rd_d = rd; acc_d = acc;
    rtype_d = rtype; rdl_d = rdl;
    tok_valid_o = 1'b0;
    tok_o = '{kind: '0, section: sec, role: rd, value: '0, is_flags: 1'b0};
    unique case (ph)
      dmp_pkg::PH_HDR: begin
        acc_d = {16'd0, hv};
        idx_d = idx_inc;
        if (!idx_inc[0]) begin
          tok_valid_o = 1'b1;
          tok_o.kind  = 4'(idx_inc[3:1] - 3'd1);
          tok_o.value = {16'd0, hv};
          tok_o.is_flags = idx_inc == 4'd4;
          if (idx_inc == 4'd6) left_d = hv;
          if (idx_inc == 4'd8) an_d = hv;
          if (idx_inc == 4'd10) ns_d = hv;
          if (idx_inc == 4'd12) begin
            ar_d = hv; acc_d = '0; idx_d = '0; rd_d = 1'b0;
            sec_d = sk_sec; left_d = sk_left;
            phase_d = sk_done ? dmp_pkg::PH_DONE : dmp_pkg::PH_NAME;
            lbl_d = '0; first_d = 1'b1;
          end
        end
      end
      dmp_pkg::PH_NAME: begin
        tok_valid_o = 1'b1;
        if (lbl != '0) begin
          tok_o.kind = dmp_pkg::TK_NAME_CHAR; tok_o.value = {24'd0, data_byte_i};
          lbl_d = lbl - 8'd1;
        end else if (data_byte_i == '0) begin
          tok_o.kind = dmp_pkg::TK_NAME_END;
          if (rd) begin
            rd_d = 1'b0; sec_d = sk_sec; left_d = sk_left; lbl_d = '0; first_d = 1'b1;
            phase_d = sk_done ? dmp_pkg::PH_DONE : dmp_pkg::PH_NAME;
          end else begin
            phase_d = sec == dmp_pkg::SEC_QD ? dmp_pkg::PH_QTYPE : dmp_pkg::PH_RTYPE;
            idx_d = '0; acc_d = '0;
          end
        end else begin
          lbl_d = data_byte_i;
          if (fst) begin
            first_d = 1'b0; tok_valid_o = 1'b0;
          end else begin
            tok_o.kind = dmp_pkg::TK_NAME_CHAR; tok_o.value = {24'd0, dmp_pkg::DOT_CHAR};
          end
        end
      end
      dmp_pkg::PH_QTYPE, dmp_pkg::PH_QCLASS, dmp_pkg::PH_RTYPE, dmp_pkg::PH_RCLASS,
      dmp_pkg::PH_RTTL, dmp_pkg::PH_RDLEN, dmp_pkg::PH_RD_PREF: begin
        acc_d = shifted; idx_d = idx_inc;
        if (idx_inc == ((ph == dmp_pkg::PH_RTTL) ? 4'd4 : 4'd2)) begin
          tok_valid_o = 1'b1; idx_d = '0; acc_d = '0;
          tok_o.value = (ph == dmp_pkg::PH_RTTL) ? shifted : {16'd0, shifted[15:0]};
          case (ph)
            dmp_pkg::PH_QTYPE: begin
              tok_o.kind = dmp_pkg::TK_TYPE; phase_d = dmp_pkg::PH_QCLASS;
            end
            dmp_pkg::PH_QCLASS: begin
              tok_o.kind = dmp_pkg::TK_CLASS; rd_d = 1'b0; sec_d = sk_sec;
              left_d = sk_left; lbl_d = '0; first_d = 1'b1;
              phase_d = sk_done ? dmp_pkg::PH_DONE : dmp_pkg::PH_NAME;
            end
            dmp_pkg::PH_RTYPE: begin
              rtype_d = shifted[15:0];
              tok_o.kind = known ? dmp_pkg::TK_TYPE : dmp_pkg::TK_UNKNOWN;
              phase_d = dmp_pkg::PH_RCLASS;
            end
            dmp_pkg::PH_RCLASS: begin
              tok_o.kind = dmp_pkg::TK_CLASS; phase_d = dmp_pkg::PH_RTTL;
            end
            dmp_pkg::PH_RTTL: begin
              tok_o.kind = dmp_pkg::TK_TTL; phase_d = dmp_pkg::PH_RDLEN;
            end
            dmp_pkg::PH_RDLEN: begin
              tok_o.kind = dmp_pkg::TK_RDLEN;
              if (rtype == dmp_pkg::TYPE_A) phase_d = dmp_pkg::PH_RD_A;
              else if (rtype == dmp_pkg::TYPE_MX) phase_d = dmp_pkg::PH_RD_PREF;
              else if (rtype == dmp_pkg::TYPE_NS || rtype == dmp_pkg::TYPE_CNAME ||
                       rtype == dmp_pkg::TYPE_PTR) begin
                rd_d = 1'b1; phase_d = dmp_pkg::PH_NAME; lbl_d = '0; first_d = 1'b1;
              end else begin
                rdl_d = shifted[15:0];
                if (shifted[15:0] == '0) begin
                  rd_d = 1'b0; sec_d = sk_sec; left_d = sk_left; lbl_d = '0;
                  first_d = 1'b1;
                  phase_d = sk_done ? dmp_pkg::PH_DONE : dmp_pkg::PH_NAME;
                end else phase_d = dmp_pkg::PH_RD_SKIP;
              end
            end
            default: begin
              tok_o.kind = dmp_pkg::TK_PREF; rd_d = 1'b1;
              phase_d = dmp_pkg::PH_NAME; lbl_d = '0; first_d = 1'b1;
            end
          endcase
        end
      end
      dmp_pkg::PH_RD_A: begin
        tok_valid_o = 1'b1; tok_o.kind = dmp_pkg::TK_ADDR;
        tok_o.value = {24'd0, data_byte_i};
        acc_d = shifted; idx_d = idx_inc;
        if (idx_inc == 4'd4) begin
          rd_d = 1'b0; sec_d = sk_sec; left_d = sk_left; lbl_d = '0; first_d = 1'b1;
          phase_d = sk_done ? dmp_pkg::PH_DONE : dmp_pkg::PH_NAME;
        end
      end
      dmp_pkg::PH_RD_SKIP: begin
        rdl_d = rdl - 16'd1;
        if (rdl == 16'd1) begin
          rd_d = 1'b0; sec_d = sk_sec; left_d = sk_left; lbl_d = '0; first_d = 1'b1;
          phase_d = sk_done ? dmp_pkg::PH_DONE : dmp_pkg::PH_NAME;
        end
      end
      dmp_pkg::PH_DONE: begin
        tok_valid_o = 1'b1; tok_o.kind = dmp_pkg::TK_DONE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dmp_pkg::PH_IDLE; idx_q <= '0; sec_q <= '0; left_q <= '0;
      an_q <= '0; ns_q <= '0; ar_q <= '0; lbl_q <= '0; first_q <= 1'b1;
      rd_q <= 1'b0; acc_q <= '0; rtype_q <= '0; rdl_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d; idx_q <= idx_d; sec_q <= sec_d; left_q <= left_d;
      an_q <= an_d; ns_q <= ns_d; ar_q <= ar_d; lbl_q <= lbl_d; first_q <= first_d;
      rd_q <= rd_d; acc_q <= acc_d; rtype_q <= rtype_d; rdl_q <= rdl_d;
    end
  end

endmodule

>>> hdl/dns_message_parser.sv
// dns message parser top level: one byte item in, at most one token item out
// output: tokens are registered in out_q, via the skid slot when the output stalls
// throughput: one byte per cycle while the skid slot is free
// reset: asynchronous active low, parser idle until a byte with first_byte set
// depends on dmp_pkg and dmp_core
module dns_message_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [2:0]  section_o,
  output logic        name_role_o,
  output logic [31:0] token_value_o,
  output logic        flag_qr_o,
  output logic [3:0]  flag_opcode_o,
  output logic        flag_aa_o,
  output logic        flag_tc_o,
  output logic        flag_rd_o,
  output logic        flag_ra_o,
  output logic [3:0]  flag_rcode_o
);

  logic            step, tok_valid, out_valid_q, skid_valid_q;
  dmp_pkg::token_t tok, out_q, skid_q, head;

  // input accepted whenever the skid slot is free
  assign in_stall_o = skid_valid_q;
  assign step       = in_valid_i && !skid_valid_q;

  dmp_core u_core (
    .clk_i, .rst_ni, .step_i(step), .data_byte_i, .first_byte_i,
    .tok_valid_o(tok_valid), .tok_o(tok)
  );

  assign head = skid_valid_q ? skid_q : tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || !out_stall_i) begin
        out_valid_q  <= skid_valid_q || (step && tok_valid);
        skid_valid_q <= 1'b0;
      end else if (step && tok_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) out_q <= head;
    else if (step && tok_valid) skid_q <= tok;
  end

  assign out_valid_o   = out_valid_q;
  assign token_kind_o  = out_q.kind;
  assign section_o     = out_q.section;
  assign name_role_o   = out_q.role;
  assign token_value_o = out_q.value;
  assign flag_qr_o     = out_q.is_flags & out_q.value[15];
  assign flag_opcode_o = out_q.is_flags ? out_q.value[14:11] : 4'd0;
  assign flag_aa_o     = out_q.is_flags & out_q.value[10];
  assign flag_tc_o     = out_q.is_flags & out_q.value[9];
  assign flag_rd_o     = out_q.is_flags & out_q.value[8];
  assign flag_ra_o     = out_q.is_flags & out_q.value[7];
  assign flag_rcode_o  = out_q.is_flags ? out_q.value[3:0] : 4'd0;

endmodule

>>> hdl/dmp_checker.sv
// port-level checks for the dns message parser, bound to the top level
// depends on dmp_pkg
module dmp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  token_kind_o,
  input logic [2:0]  section_o,
  input logic [31:0] token_value_o,
  input logic [3:0]  flag_opcode_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_value_o))
    else $error("stalled item changed");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == dmp_pkg::TK_DONE |-> section_o == dmp_pkg::SEC_AR
    && token_value_o == '0) else $error("bad done item");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != dmp_pkg::TK_FLAGS |-> flag_opcode_o == '0)
    else $error("flags outside flags item");

  a_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o <= dmp_pkg::TK_ARCOUNT |-> section_o == dmp_pkg::SEC_HDR)
    else $error("header item outside header");

endmodule

bind dns_message_parser dmp_checker u_dmp_checker (.*);

>>> test/dmp_token_checker.sv
`timescale 1ns / 100ps
// token checker for the dns message parser: tracks parser state from accepted bytes,
// predicts the token each byte yields and compares it with the tokens the block emits
// depends on dmp_pkg
module dmp_token_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [3:0]  token_kind_i,
  input  logic [2:0]  section_i,
  input  logic        name_role_i,
  input  logic [31:0] token_value_i,
  input  logic        flag_qr_i,
  input  logic [3:0]  flag_opcode_i,
  input  logic        flag_aa_i,
  input  logic        flag_tc_i,
  input  logic        flag_rd_i,
  input  logic        flag_ra_i,
  input  logic [3:0]  flag_rcode_i,
  output int          pending_o,
  output int          fail_count_o,
  output int          tokens_seen_o
);

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  section;
    logic        role;
    logic [31:0] value;
    logic [12:0] flags;  // qr, opcode, aa, tc, rd, ra, rcode
  } token_exp_t;

  token_exp_t  token_q[$];

  dmp_pkg::phase_e phase;
  logic [3:0]  byte_idx;
  logic [2:0]  cur_sec;
  logic [15:0] recs_left, an_cnt, ns_cnt, ar_cnt, rec_type, skip_left;
  logic [7:0]  label_left;
  logic        first_label, in_rdata;
  logic [31:0] acc;

  assign pending_o = token_q.size();

  function automatic bit known_type(input logic [15:0] t);
    return t == dmp_pkg::TYPE_A || t == dmp_pkg::TYPE_NS || t == dmp_pkg::TYPE_CNAME ||
           t == dmp_pkg::TYPE_PTR || t == dmp_pkg::TYPE_MX;
  endfunction

  task automatic clear_state();
    phase = dmp_pkg::PH_IDLE;
    byte_idx = '0;
    cur_sec = dmp_pkg::SEC_HDR;
    recs_left = '0;
    an_cnt = '0;
    ns_cnt = '0;
    ar_cnt = '0;
    label_left = '0;
    first_label = 1'b1;
    in_rdata = 1'b0;
    acc = '0;
    rec_type = '0;
    skip_left = '0;
  endtask

  task automatic push_token(input logic [3:0] kind, input logic [31:0] value,
                            input logic [12:0] flags);
    token_exp_t t;
    t.kind = kind;
    t.section = cur_sec;
    t.role = in_rdata;
    t.value = value;
    t.flags = flags;
    token_q.push_back(t);
  endtask

  task automatic start_name();
    phase = dmp_pkg::PH_NAME;
    label_left = '0;
    first_label = 1'b1;
  endtask

  task automatic next_item();
    while (recs_left == 0) begin
      if (cur_sec == dmp_pkg::SEC_QD) begin
        cur_sec = dmp_pkg::SEC_AN;
        recs_left = an_cnt;
      end else if (cur_sec == dmp_pkg::SEC_AN) begin
        cur_sec = dmp_pkg::SEC_NS;
        recs_left = ns_cnt;
      end else if (cur_sec == dmp_pkg::SEC_NS) begin
        cur_sec = dmp_pkg::SEC_AR;
        recs_left = ar_cnt;
      end else begin
        cur_sec = dmp_pkg::SEC_AR;
        phase = dmp_pkg::PH_DONE;
        return;
      end
    end
    in_rdata = 1'b0;
    start_name();
  endtask

  task automatic close_item();
    recs_left = recs_left - 16'd1;
    in_rdata = 1'b0;
    next_item();
  endtask

  task automatic open_field(input dmp_pkg::phase_e p);
    phase = p;
    byte_idx = '0;
    acc = '0;
  endtask

  function automatic bit shift_in(input logic [7:0] b, input logic [3:0] n);
    acc = {acc[23:0], b};
    byte_idx = byte_idx + 4'd1;
    return byte_idx == n;
  endfunction

  // advance the parser by one byte, queueing the token it yields if any
  task automatic parse_byte(input logic [7:0] b, input logic fb);
    logic [15:0] v;
    if (fb) begin
      clear_state();
      phase = dmp_pkg::PH_HDR;
    end
    case (phase)
      dmp_pkg::PH_HDR: begin
        acc = {16'h0, acc[7:0], b};
        v = acc[15:0];
        byte_idx = byte_idx + 4'd1;
        if (!byte_idx[0]) begin
          if (byte_idx == 4'd4)
            push_token(dmp_pkg::TK_FLAGS, {16'd0, v},
                       {v[15], v[14:11], v[10], v[9], v[8], v[7], v[3:0]});
          else
            push_token(dmp_pkg::TK_ID + ((byte_idx - 4'd2) >> 1), {16'd0, v}, '0);
          if (byte_idx == 4'd6) recs_left = v;
          else if (byte_idx == 4'd8) an_cnt = v;
          else if (byte_idx == 4'd10) ns_cnt = v;
          else if (byte_idx == 4'd12) begin
            ar_cnt = v;
            cur_sec = dmp_pkg::SEC_QD;
            acc = '0;
            byte_idx = '0;
            next_item();
          end
        end
      end
      dmp_pkg::PH_NAME: begin
        if (label_left != 0) begin
          push_token(dmp_pkg::TK_NAME_CHAR, {24'd0, b}, '0);
          label_left = label_left - 8'd1;
        end else if (b == 0) begin
          push_token(dmp_pkg::TK_NAME_END, '0, '0);
          if (in_rdata) close_item();
          else if (cur_sec == dmp_pkg::SEC_QD) open_field(dmp_pkg::PH_QTYPE);
          else open_field(dmp_pkg::PH_RTYPE);
        end else begin
          label_left = b;
          if (first_label) first_label = 1'b0;
          else push_token(dmp_pkg::TK_NAME_CHAR, {24'd0, dmp_pkg::DOT_CHAR}, '0);
        end
      end
      dmp_pkg::PH_QTYPE: if (shift_in(b, 4'd2)) begin
        push_token(dmp_pkg::TK_TYPE, {16'd0, acc[15:0]}, '0);
        open_field(dmp_pkg::PH_QCLASS);
      end
      dmp_pkg::PH_QCLASS: if (shift_in(b, 4'd2)) begin
        push_token(dmp_pkg::TK_CLASS, {16'd0, acc[15:0]}, '0);
        close_item();
      end
      dmp_pkg::PH_RTYPE: if (shift_in(b, 4'd2)) begin
        rec_type = acc[15:0];
        push_token(known_type(rec_type) ? dmp_pkg::TK_TYPE : dmp_pkg::TK_UNKNOWN,
                   {16'd0, rec_type}, '0);
        open_field(dmp_pkg::PH_RCLASS);
      end
      dmp_pkg::PH_RCLASS: if (shift_in(b, 4'd2)) begin
        push_token(dmp_pkg::TK_CLASS, {16'd0, acc[15:0]}, '0);
        open_field(dmp_pkg::PH_RTTL);
      end
      dmp_pkg::PH_RTTL: if (shift_in(b, 4'd4)) begin
        push_token(dmp_pkg::TK_TTL, acc, '0);
        open_field(dmp_pkg::PH_RDLEN);
      end
      dmp_pkg::PH_RDLEN: if (shift_in(b, 4'd2)) begin
        v = acc[15:0];
        push_token(dmp_pkg::TK_RDLEN, {16'd0, v}, '0);
        if (rec_type == dmp_pkg::TYPE_A) open_field(dmp_pkg::PH_RD_A);
        else if (rec_type == dmp_pkg::TYPE_MX) open_field(dmp_pkg::PH_RD_PREF);
        else if (known_type(rec_type)) begin
          in_rdata = 1'b1;
          start_name();
        end else begin
          skip_left = v;
          if (v == 0) close_item();
          else phase = dmp_pkg::PH_RD_SKIP;
        end
      end
      dmp_pkg::PH_RD_A: begin
        push_token(dmp_pkg::TK_ADDR, {24'd0, b}, '0);
        if (shift_in(b, 4'd4)) close_item();
      end
      dmp_pkg::PH_RD_PREF: if (shift_in(b, 4'd2)) begin
        push_token(dmp_pkg::TK_PREF, {16'd0, acc[15:0]}, '0);
        in_rdata = 1'b1;
        start_name();
      end
      dmp_pkg::PH_RD_SKIP: begin
        skip_left = skip_left - 16'd1;
        if (skip_left == 0) close_item();
      end
      dmp_pkg::PH_DONE: push_token(dmp_pkg::TK_DONE, '0, '0);
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    token_exp_t e;
    logic [12:0] got_flags;
    if (!rst_ni) begin
      clear_state();
      token_q.delete();
      fail_count_o <= 0;
      tokens_seen_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        tokens_seen_o <= tokens_seen_o + 1;
        got_flags = {flag_qr_i, flag_opcode_i, flag_aa_i, flag_tc_i, flag_rd_i, flag_ra_i,
                     flag_rcode_i};
        if (token_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected item kind %0d value %0h", $realtime, token_kind_i,
                     token_value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = token_q.pop_front();
          if (e.kind !== token_kind_i || e.section !== section_i || e.role !== name_role_i ||
              e.value !== token_value_i || e.flags !== got_flags) begin
            if (fail_count_o < 10)
              $display("%0t: mismatch exp kind %0d sec %0d role %0b val %0h flags %0h, got %0d %0d %0b %0h %0h",
                       $realtime, e.kind, e.section, e.role, e.value, e.flags, token_kind_i,
                       section_i, name_role_i, token_value_i, got_flags);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) parse_byte(data_byte_i, first_byte_i);
    end
  end

endmodule

>>> test/tb_dns_message_parser.sv
`timescale 1ns / 100ps
// testbench top for dns_message_parser: builds random dns messages and noise, drives
// them with random gaps and output stalls; depends on dmp_pkg and dmp_token_checker
module tb_dns_message_parser;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        first_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  token_kind, flag_opcode, flag_rcode;
  logic [2:0]  section;
  logic        name_role, flag_qr, flag_aa, flag_tc, flag_rd, flag_ra;
  logic [31:0] token_value;
  logic        in_taken = 1'b0;
  int          pending, fail_count, tokens_seen;
  int          bytes_sent = 0, burst_left = 0, msgs = 0;
  logic [7:0]  msg_q[$];
  logic        first_q[$];

  always #2 clk_i = ~clk_i;

  dns_message_parser DUT (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_stall_o(in_stall),
    .data_byte_i(data_byte), .first_byte_i(first_byte), .out_valid_o(out_valid),
    .out_stall_i(out_stall), .token_kind_o(token_kind), .section_o(section),
    .name_role_o(name_role), .token_value_o(token_value), .flag_qr_o(flag_qr),
    .flag_opcode_o(flag_opcode), .flag_aa_o(flag_aa), .flag_tc_o(flag_tc),
    .flag_rd_o(flag_rd), .flag_ra_o(flag_ra), .flag_rcode_o(flag_rcode)
  );

  dmp_token_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_stall_i(in_stall),
    .data_byte_i(data_byte), .first_byte_i(first_byte), .out_valid_i(out_valid),
    .out_stall_i(out_stall), .token_kind_i(token_kind), .section_i(section),
    .name_role_i(name_role), .token_value_i(token_value), .flag_qr_i(flag_qr),
    .flag_opcode_i(flag_opcode), .flag_aa_i(flag_aa), .flag_tc_i(flag_tc),
    .flag_rd_i(flag_rd), .flag_ra_i(flag_ra), .flag_rcode_i(flag_rcode),
    .pending_o(pending), .fail_count_o(fail_count), .tokens_seen_o(tokens_seen)
  );

  always @(posedge clk_i) in_taken <= in_valid && !in_stall;

  // receiver stall pattern: phases of no stall, light random stall and heavy random stall
  int stall_mode = 0, stall_len = 0;
  always @(negedge clk_i) begin
    if (stall_len == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_len = $urandom_range(20, 150);
    end
    stall_len = stall_len - 1;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  initial begin
    #2000000;
    $display("dns_message_parser regression: fail");
    $finish;
  end

  task automatic put(input logic [7:0] b, input logic fb = 1'b0);
    msg_q.push_back(b);
    first_q.push_back(fb);
  endtask

  task automatic put16(input logic [15:0] v);
    put(v[15:8]);
    put(v[7:0]);
  endtask

  task automatic put_header(input logic [15:0] qd, an, ns, ar);
    logic [15:0] id;
    id = 16'($urandom);
    put(id[15:8], 1'b1);
    put(id[7:0]);
    put16(16'($urandom));
    put16(qd);
    put16(an);
    put16(ns);
    put16(ar);
  endtask

  task automatic put_name();
    int labels, len;
    labels = $urandom_range(0, 3);
    for (int l = 0; l < labels; l++) begin
      // a compression pointer byte is taken as a long label
      len = ($urandom_range(0, 60) == 0) ? 8'hC0 : $urandom_range(1, 6);
      put(8'(len));
      for (int c = 0; c < len; c++) put(8'($urandom));
    end
    put(8'h00);
  endtask

  task automatic put_record();
    logic [15:0] rtype;
    int len, pick;
    put_name();
    pick = $urandom_range(0, 5);
    case (pick)
      0: rtype = dmp_pkg::TYPE_A;
      1: rtype = dmp_pkg::TYPE_NS;
      2: rtype = dmp_pkg::TYPE_CNAME;
      3: rtype = dmp_pkg::TYPE_PTR;
      4: rtype = dmp_pkg::TYPE_MX;
      default: begin
        rtype = 16'($urandom);
        if (rtype == dmp_pkg::TYPE_A || rtype == dmp_pkg::TYPE_NS ||
            rtype == dmp_pkg::TYPE_CNAME || rtype == dmp_pkg::TYPE_PTR ||
            rtype == dmp_pkg::TYPE_MX)
          rtype = 16'hFFFF;
      end
    endcase
    put16(rtype);
    put16(16'($urandom));
    put16(16'($urandom));
    put16(16'($urandom));
    if (pick == 5) begin
      len = $urandom_range(0, 5);
      put16(16'(len));
      for (int i = 0; i < len; i++) put(8'($urandom));
    end else begin
      put16(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd4);
      if (rtype == dmp_pkg::TYPE_A) for (int i = 0; i < 4; i++) put(8'($urandom));
      else begin
        if (rtype == dmp_pkg::TYPE_MX) put16(16'($urandom));
        put_name();
      end
    end
  endtask

  task automatic put_message();
    int qd, an, ns, ar, start, cut;
    start = msg_q.size();
    qd = $urandom_range(0, 2);
    an = $urandom_range(0, 3);
    ns = $urandom_range(0, 2);
    ar = $urandom_range(0, 2);
    if ($urandom_range(0, 15) == 0) begin
      qd = 0; an = 0; ns = 0; ar = 0;
    end
    put_header(16'(qd), 16'(an), 16'(ns), 16'(ar));
    for (int i = 0; i < qd; i++) begin
      put_name();
      put16(16'($urandom));
      put16(16'($urandom));
    end
    for (int i = 0; i < an + ns + ar; i++) put_record();
    // broken message: dropped part way by the next restart
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(start + 1, msg_q.size());
      while (msg_q.size() > cut) begin
        void'(msg_q.pop_back());
        void'(first_q.pop_back());
      end
    end
    repeat ($urandom_range(0, 3)) put(8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fb);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
    end
    in_valid = 1'b1;
    data_byte = b;
    first_byte = fb;
    do @(negedge clk_i); while (!in_taken);
    burst_left = burst_left - 1;
    bytes_sent = bytes_sent + 1;
  endtask

  task automatic flush_queue();
    while (msg_q.size() > 0) send_byte(msg_q.pop_front(), first_q.pop_front());
  endtask

  initial begin
    int waited;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: bytes while idle, empty message with done bytes, restart mid-header,
    // header of extreme counts cut short by a new message
    put(8'hFF);
    put(8'h00);
    put_header(16'd0, 16'd0, 16'd0, 16'd0);
    put(8'hFF);
    put(8'h00);
    put(8'hAA, 1'b1);
    put(8'h55);
    put(8'h80);
    put_header(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    put(8'h00, 1'b1);
    flush_queue();

    while (bytes_sent < 1850) begin
      put_message();
      msgs = msgs + 1;
      flush_queue();
      if (msgs == 10) begin
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
    end
    in_valid = 1'b0;

    waited = 0;
    while (pending != 0 && waited < 100000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (5) @(negedge clk_i);
    $display("sent %0d bytes in %0d random messages plus directed cases, %0d tokens checked",
             bytes_sent, msgs, tokens_seen);
    if (fail_count == 0 && pending == 0) $display("dns_message_parser regression: pass");
    else $display("dns_message_parser regression: fail");
    $finish;
  end

endmodule
